// ===== hdl/emboss_shade_filter_unit_defines.svh =====
// Assertion macros shared by the emboss shade filter modules.
// Needs clk and arst_n in the scope of each use.
`ifndef EMBOSS_SHADE_FILTER_UNIT_DEFINES_SVH
`define EMBOSS_SHADE_FILTER_UNIT_DEFINES_SVH

// same-cycle implication
`define ESF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ESF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/esf_pkg.sv =====
// Types and constants of the emboss shade filter.
// No dependencies; used by all modules of the block.
package esf_pkg;

	// register map, index = byte address / 4
	typedef enum logic [2:0] {
		REG_WIDTH  = 3'd0,
		REG_HEIGHT = 3'd1,
		REG_LX     = 3'd2,
		REG_LY     = 3'd3,
		REG_LZ     = 3'd4,
		REG_NZ     = 3'd5
	} reg_idx_t;

	localparam logic [11:0] RST_WIDTH  = 12'd640;
	localparam logic [15:0] RST_HEIGHT = 16'd480;
	localparam logic [8:0]  RST_LX     = 9'h164;   // -156
	localparam logic [8:0]  RST_LY     = 9'd156;
	localparam logic [7:0]  RST_LZ     = 8'd127;
	localparam logic [10:0] RST_NZ     = 11'd153;

	// luma = sum * RECIP >> SHIFT, exact divide by 3 for sums up to 765
	localparam logic [15:0] LUMA_RECIP = 16'd43691;
	localparam int          LUMA_SHIFT = 17;

	// root unit widths; the norm reaches 2*765^2 + 2047^2 for an 11-bit normal_z
	localparam int MUL_W  = 23;
	localparam int PROD_W = 44;
	localparam int S_W    = 23;
	localparam int TT_W   = 18;
	localparam int Q_W    = 9;

	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = 2;
	localparam int Q_CNT_W = 3;

	typedef struct packed {
		logic [11:0] width;
		logic [15:0] height;
		logic [8:0]  lx;
		logic [8:0]  ly;
		logic [7:0]  lz;
		logic [10:0] nz;
	} cfg_t;

	// work handed from front to back
	typedef struct packed {
		logic        root;    // 1: shade needs the square root
		logic [7:0]  shade;   // fixed shade when root is 0
		logic [7:0]  alpha;
		logic        last;
		logic [19:0] ndotl;   // non-negative dot product
		logic [10:0] nx;      // two's complement gradient
		logic [10:0] ny;
		logic [10:0] nz;
	} job_t;

endpackage

// ===== hdl/esf_pix_if.sv =====
// Input pixel channel of the emboss shade filter.
// Depends on nothing.
interface esf_pix_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] alpha;

	modport source (output valid, mode, red, green, blue, alpha, input ready);
	modport sink   (input valid, mode, red, green, blue, alpha, output ready);
endinterface

// ===== hdl/esf_res_if.sv =====
// Result channel of the emboss shade filter.
// Depends on nothing.
interface esf_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] shade;
	logic [7:0] alpha_out;
	logic       last_of_frame;

	modport source (output valid, shade, alpha_out, last_of_frame, input ready);
	modport sink   (input valid, shade, alpha_out, last_of_frame, output ready);
endinterface

// ===== hdl/esf_queue.sv =====
// Short job queue between front and back of the emboss shade filter.
// Depends on esf_pkg and the assertion macros.
`include "emboss_shade_filter_unit_defines.svh"

module esf_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  esf_pkg::job_t din,
	output logic          full,
	input  logic          pop,
	output esf_pkg::job_t dout,
	output logic          empty
);

	esf_pkg::job_t                      slot_q [esf_pkg::Q_DEPTH];
	logic [esf_pkg::Q_PTR_W-1:0]        wr_q;
	logic [esf_pkg::Q_PTR_W-1:0]        rd_q;
	logic [esf_pkg::Q_CNT_W-1:0]        count_q;

	assign full  = (count_q == esf_pkg::Q_CNT_W'(esf_pkg::Q_DEPTH));
	assign empty = (count_q == '0);
	assign dout  = slot_q[rd_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= din;
	end

	`ESF_ASSERT_NOW(a_pop_nonempty, pop, !empty, "queue popped while empty")
	`ESF_ASSERT_NOW(a_count_bound, 1'b1, count_q <= esf_pkg::Q_CNT_W'(esf_pkg::Q_DEPTH), "queue level out of range")

endmodule

// ===== hdl/esf_front.sv =====
// Front of the emboss shade filter: accepts items, keeps the line buffers,
// the 3x3 window, the alpha delay and the frame position, and queues jobs.
// Depends on esf_pkg, esf_pix_if and the assertion macros.
`include "emboss_shade_filter_unit_defines.svh"

module esf_front #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic          clk,
	input  logic          arst_n,
	input  esf_pkg::cfg_t cfg,
	esf_pix_if.sink       pix,
	output logic          q_push,
	output esf_pkg::job_t q_data,
	input  logic          q_full
);

	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int WEFF_W  = $clog2(MAX_WIDTH + 1);
	localparam int A_DEPTH = 2 * MAX_WIDTH + 2;
	localparam int A_W     = $clog2(A_DEPTH);
	localparam int FILL_W  = $clog2(2 * MAX_WIDTH + 3);
	localparam int D_W     = FILL_W + 1;

	typedef enum logic [4:0] {
		F_IDLE = 5'b00001,
		F_WIN  = 5'b00010,
		F_GRAD = 5'b00100,
		F_MUL  = 5'b01000,
		F_PUSH = 5'b10000
	} fstate_t;

	fstate_t             state_q;
	logic [FILL_W-1:0]   fill_q;
	logic [A_W-1:0]      a_wp_q;
	logic [COL_W-1:0]    lb_ptr_q;
	logic [COL_W-1:0]    col_q;
	logic [15:0]         row_q;
	logic                is_pix_q;
	logic                emit_q;
	logic                inner_q;
	logic                last_q;

	logic [7:0]          alpha_mem [A_DEPTH];
	logic [7:0]          lb1_mem [MAX_WIDTH];
	logic [7:0]          lb2_mem [MAX_WIDTH];
	logic [7:0]          alpha_rd_q;
	logic [7:0]          lb1_rd_q;
	logic [7:0]          lb2_rd_q;
	logic [7:0]          luma_q;
	logic [7:0]          win_q [3][3];   // [column][row], column 0 newest, row 0 newest line
	logic signed [10:0]  nx_q;
	logic signed [10:0]  ny_q;
	logic signed [19:0]  px_q;
	logic signed [19:0]  py_q;
	logic [18:0]         pz_q;

	logic [WEFF_W-1:0]   w_eff;
	logic [15:0]         h_eff;
	logic [FILL_W-1:0]   lag;
	logic                accept;
	logic                is_pix;
	logic [FILL_W-1:0]   fill_clamp;
	logic [FILL_W-1:0]   fill_inc;
	logic                emit_c;
	logic [FILL_W-1:0]   fill_nx;
	logic [FILL_W-1:0]   age_c;
	logic [A_W-1:0]      wp_next;
	logic [D_W-1:0]      diff;
	logic [A_W-1:0]      raddr;
	logic [9:0]          luma_sum;
	logic [25:0]         luma_prod;
	logic                inner_c;
	logic                col_end;
	logic                row_end;
	logic [9:0]          sum_c0;
	logic [9:0]          sum_c2;
	logic [9:0]          sum_r0;
	logic [9:0]          sum_r2;
	logic signed [21:0]  ndotl_c;

	// effective geometry
	always_comb begin
		if (cfg.width == '0) w_eff = WEFF_W'(1);
		else if (32'(cfg.width) > MAX_WIDTH) w_eff = WEFF_W'(MAX_WIDTH);
		else w_eff = WEFF_W'(cfg.width);
		h_eff = (cfg.height == '0) ? 16'd1 : cfg.height;
		lag   = FILL_W'({w_eff, 1'b1});
	end

	assign pix.ready = (state_q == F_IDLE) && !q_full;
	assign accept    = pix.valid && pix.ready;
	assign is_pix    = !pix.mode;

	// pending count and alpha read age of the item on the port
	always_comb begin
		fill_clamp = (fill_q > lag) ? lag : fill_q;
		fill_inc   = fill_q + 1'b1;
		if (is_pix) begin
			emit_c  = fill_inc > lag;
			fill_nx = emit_c ? lag : fill_inc;
			age_c   = lag;
			wp_next = (a_wp_q == A_W'(A_DEPTH - 1)) ? '0 : a_wp_q + 1'b1;
		end else begin
			emit_c  = (fill_clamp != '0);
			fill_nx = emit_c ? fill_clamp - 1'b1 : fill_clamp;
			age_c   = fill_clamp - 1'b1;
			wp_next = a_wp_q;
		end
		diff = D_W'(wp_next) - D_W'(age_c);
		if (diff[D_W-1]) raddr = A_W'(diff + D_W'(A_DEPTH));
		else raddr = A_W'(diff);
	end

	// luma by reciprocal multiply
	assign luma_sum  = 10'(pix.red) + 10'(pix.green) + 10'(pix.blue);
	assign luma_prod = 26'(luma_sum) * 26'(esf_pkg::LUMA_RECIP);

	// position of the result being formed
	always_comb begin
		inner_c = is_pix_q && (row_q != '0) && (17'(row_q) + 17'd2 < 17'(h_eff))
			&& (col_q != '0) && (32'(col_q) + 32'd2 < 32'(w_eff));
		col_end = (32'(col_q) + 32'd1 >= 32'(w_eff));
		row_end = (17'(row_q) + 17'd1 >= 17'(h_eff));
	end

	// gradients from the window
	always_comb begin
		sum_c0 = 10'(win_q[0][0]) + 10'(win_q[0][1]) + 10'(win_q[0][2]);
		sum_c2 = 10'(win_q[2][0]) + 10'(win_q[2][1]) + 10'(win_q[2][2]);
		sum_r0 = 10'(win_q[0][0]) + 10'(win_q[1][0]) + 10'(win_q[2][0]);
		sum_r2 = 10'(win_q[0][2]) + 10'(win_q[1][2]) + 10'(win_q[2][2]);
		ndotl_c = 22'(px_q) + 22'(py_q) + 22'(pz_q);
	end

	// job classification
	always_comb begin
		q_push          = (state_q == F_PUSH);
		q_data.alpha    = alpha_rd_q;
		q_data.last     = last_q;
		q_data.ndotl    = ndotl_c[19:0];
		q_data.nx       = nx_q;
		q_data.ny       = ny_q;
		q_data.nz       = cfg.nz;
		q_data.root     = 1'b0;
		q_data.shade    = cfg.lz;
		if (inner_q && !(nx_q == '0 && ny_q == '0)) begin
			if (ndotl_c[21]) q_data.shade = 8'd0;
			else q_data.root = 1'b1;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= F_IDLE;
			fill_q   <= '0;
			a_wp_q   <= '0;
			lb_ptr_q <= '0;
			col_q    <= '0;
			row_q    <= '0;
			is_pix_q <= 1'b0;
			emit_q   <= 1'b0;
			inner_q  <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						fill_q   <= fill_nx;
						a_wp_q   <= wp_next;
						is_pix_q <= is_pix;
						emit_q   <= emit_c;
						state_q  <= F_WIN;
					end
				end
				F_WIN: begin
					if (is_pix_q) begin
						lb_ptr_q <= (32'(lb_ptr_q) + 32'd1 >= 32'(w_eff)) ? '0 : lb_ptr_q + 1'b1;
					end
					if (emit_q) begin
						inner_q <= inner_c;
						last_q  <= col_end && row_end;
						if (col_end) begin
							col_q <= '0;
							row_q <= row_end ? '0 : row_q + 1'b1;
						end else begin
							col_q <= col_q + 1'b1;
						end
						state_q <= F_GRAD;
					end else begin
						state_q <= F_IDLE;
					end
				end
				F_GRAD: state_q <= F_MUL;
				F_MUL: state_q <= F_PUSH;
				F_PUSH: state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// memories, window and arithmetic
	always_ff @(posedge clk) begin
		if (accept) begin
			if (is_pix) alpha_mem[wp_next] <= pix.alpha;
			alpha_rd_q <= alpha_mem[raddr];
			lb1_rd_q   <= lb1_mem[lb_ptr_q];
			lb2_rd_q   <= lb2_mem[lb_ptr_q];
			luma_q     <= luma_prod[esf_pkg::LUMA_SHIFT+7:esf_pkg::LUMA_SHIFT];
		end
		if (state_q == F_WIN && is_pix_q) begin
			lb1_mem[lb_ptr_q] <= luma_q;
			lb2_mem[lb_ptr_q] <= lb1_rd_q;
			win_q[2]    <= win_q[1];
			win_q[1]    <= win_q[0];
			win_q[0][0] <= luma_q;
			win_q[0][1] <= lb1_rd_q;
			win_q[0][2] <= lb2_rd_q;
		end
		if (state_q == F_GRAD) begin
			nx_q <= $signed(11'(sum_c2)) - $signed(11'(sum_c0));
			ny_q <= $signed(11'(sum_r0)) - $signed(11'(sum_r2));
		end
		if (state_q == F_MUL) begin
			px_q <= nx_q * $signed(cfg.lx);
			py_q <= ny_q * $signed(cfg.ly);
			pz_q <= 19'(cfg.nz) * 19'(cfg.lz);
		end
	end

	`ESF_ASSERT_NOW(a_push_room, q_push, !q_full, "job pushed into a full queue")
	`ESF_ASSERT_NEXT(a_busy_after_accept, pix.valid && pix.ready, !pix.ready, "second transfer while busy")

endmodule

// ===== hdl/esf_back.sv =====
// Back of the emboss shade filter: takes jobs, runs the shared-multiplier
// square root and holds the result register. Depends on esf_pkg, esf_res_if
// and the assertion macros.
`include "emboss_shade_filter_unit_defines.svh"

module esf_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  esf_pkg::job_t q_data,
	output logic          q_pop,
	esf_res_if.source     res
);

	typedef enum logic [4:0] {
		B_IDLE   = 5'b00001,
		B_PREP   = 5'b00010,
		B_ROOT_T = 5'b00100,
		B_ROOT_S = 5'b01000,
		B_OUT    = 5'b10000
	} bstate_t;

	bstate_t                      state_q;
	esf_pkg::job_t                job_q;
	logic [1:0]                   step_q;
	logic [3:0]                   bit_q;
	logic [esf_pkg::Q_W-1:0]      qv_q;
	logic [esf_pkg::PROD_W-1:0]   n2_q;
	logic [esf_pkg::S_W-1:0]      s_q;
	logic [esf_pkg::TT_W-1:0]     tt_q;
	logic                         res_valid_q;
	logic [7:0]                   shade_q;
	logic [7:0]                   alpha_q;
	logic                         last_q;

	logic [esf_pkg::MUL_W-1:0]    mul_a;
	logic [esf_pkg::MUL_W-1:0]    mul_b;
	logic [esf_pkg::PROD_W-1:0]   prod;
	logic [esf_pkg::Q_W-1:0]      trial;
	logic [10:0]                  nx_abs;
	logic [10:0]                  ny_abs;
	logic [7:0]                   shade_c;
	logic                         load;

	assign q_pop = (state_q == B_IDLE) && !q_empty;
	assign load  = (state_q == B_OUT) && (!res_valid_q || res.ready);

	assign nx_abs = job_q.nx[10] ? (~job_q.nx + 11'd1) : job_q.nx;
	assign ny_abs = job_q.ny[10] ? (~job_q.ny + 11'd1) : job_q.ny;
	assign trial  = qv_q | (esf_pkg::Q_W'(1) << bit_q);

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == B_PREP) begin
			case (step_q)
				2'd0: begin
					mul_a = esf_pkg::MUL_W'(job_q.ndotl);
					mul_b = esf_pkg::MUL_W'(job_q.ndotl);
				end
				2'd1: begin
					mul_a = esf_pkg::MUL_W'(nx_abs);
					mul_b = esf_pkg::MUL_W'(nx_abs);
				end
				2'd2: begin
					mul_a = esf_pkg::MUL_W'(ny_abs);
					mul_b = esf_pkg::MUL_W'(ny_abs);
				end
				default: begin
					mul_a = esf_pkg::MUL_W'(job_q.nz);
					mul_b = esf_pkg::MUL_W'(job_q.nz);
				end
			endcase
		end else if (state_q == B_ROOT_T) begin
			mul_a = esf_pkg::MUL_W'(trial);
			mul_b = esf_pkg::MUL_W'(trial);
		end else if (state_q == B_ROOT_S) begin
			mul_a = esf_pkg::MUL_W'(tt_q);
			mul_b = s_q;
		end
		prod = esf_pkg::PROD_W'(mul_a) * esf_pkg::PROD_W'(mul_b);
	end

	// saturated shade of a finished job
	assign shade_c = !job_q.root ? job_q.shade : (qv_q[8] ? 8'hFF : qv_q[7:0]);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			step_q      <= '0;
			bit_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res.ready && !load) res_valid_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (!q_empty) begin
						step_q  <= '0;
						state_q <= q_data.root ? B_PREP : B_OUT;
					end
				end
				B_PREP: begin
					step_q <= step_q + 1'b1;
					if (step_q == 2'd3) begin
						bit_q   <= 4'(esf_pkg::Q_W - 1);
						state_q <= B_ROOT_T;
					end
				end
				B_ROOT_T: state_q <= B_ROOT_S;
				B_ROOT_S: begin
					if (bit_q == '0) state_q <= B_OUT;
					else begin
						bit_q   <= bit_q - 1'b1;
						state_q <= B_ROOT_T;
					end
				end
				B_OUT: begin
					if (load) begin
						res_valid_q <= 1'b1;
						state_q     <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (q_pop) job_q <= q_data;
		if (state_q == B_PREP) begin
			if (step_q == 2'd0) begin
				n2_q <= prod;
				s_q  <= '0;
			end else begin
				s_q <= s_q + prod[esf_pkg::S_W-1:0];
			end
			if (step_q == 2'd3) qv_q <= '0;
		end
		if (state_q == B_ROOT_T) tt_q <= prod[esf_pkg::TT_W-1:0];
		if (state_q == B_ROOT_S && prod <= n2_q) qv_q <= trial;
		if (load) begin
			shade_q <= shade_c;
			alpha_q <= job_q.alpha;
			last_q  <= job_q.last;
		end
	end

	assign res.valid         = res_valid_q;
	assign res.shade         = shade_q;
	assign res.alpha_out     = alpha_q;
	assign res.last_of_frame = last_q;

	`ESF_ASSERT_NEXT(a_root_start, state_q == B_PREP && step_q == 2'd3, state_q == B_ROOT_T && bit_q == 4'd8, "root did not start at the top bit")
	`ESF_ASSERT_NEXT(a_load_shows, load, res_valid_q, "loaded result not shown")
	`ESF_ASSERT_NOW(a_pop_when_idle, q_pop, !res_valid_q || state_q == B_IDLE, "pop outside idle")

endmodule

// ===== hdl/emboss_shade_filter_unit.sv =====
// Emboss shade filter. Each pixel item pushes luma and alpha into line
// buffers; the result for frame position (x,y) leaves 2*width+1 pixel items
// later, and each flush item drains one pending result with shade light_z.
// The front takes one item at a time, none while the job queue is full; an
// item yielding a result passes window, gradient, multiply and push steps.
// Results come from the back through a 4-entry job queue: a border, flat or
// negative-light result goes straight out, an interior one takes 4 multiplies
// (NdotL^2 and norm) and 9 square-root steps on one shared multiplier, which
// sets the sustained rate for interior pixels. Line buffers need no clearing.
// Depends on esf_pkg, esf_pix_if, esf_res_if, esf_queue, esf_front, esf_back.
module emboss_shade_filter_unit #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	esf_pix_if.sink     pix,
	esf_res_if.source   res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	esf_pkg::cfg_t cfg_q;
	esf_pkg::job_t q_din;
	esf_pkg::job_t q_dout;
	logic          q_push;
	logic          q_pop;
	logic          q_full;
	logic          q_empty;

	assign pready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= esf_pkg::RST_WIDTH;
			cfg_q.height <= esf_pkg::RST_HEIGHT;
			cfg_q.lx     <= esf_pkg::RST_LX;
			cfg_q.ly     <= esf_pkg::RST_LY;
			cfg_q.lz     <= esf_pkg::RST_LZ;
			cfg_q.nz     <= esf_pkg::RST_NZ;
		end else if (psel && penable && pwrite) begin
			case (esf_pkg::reg_idx_t'(paddr[4:2]))
				esf_pkg::REG_WIDTH:  cfg_q.width  <= pwdata[11:0];
				esf_pkg::REG_HEIGHT: cfg_q.height <= pwdata[15:0];
				esf_pkg::REG_LX:     cfg_q.lx     <= pwdata[8:0];
				esf_pkg::REG_LY:     cfg_q.ly     <= pwdata[8:0];
				esf_pkg::REG_LZ:     cfg_q.lz     <= pwdata[7:0];
				esf_pkg::REG_NZ:     cfg_q.nz     <= pwdata[10:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		case (esf_pkg::reg_idx_t'(paddr[4:2]))
			esf_pkg::REG_WIDTH:  prdata = 32'(cfg_q.width);
			esf_pkg::REG_HEIGHT: prdata = 32'(cfg_q.height);
			esf_pkg::REG_LX:     prdata = 32'(cfg_q.lx);
			esf_pkg::REG_LY:     prdata = 32'(cfg_q.ly);
			esf_pkg::REG_LZ:     prdata = 32'(cfg_q.lz);
			esf_pkg::REG_NZ:     prdata = 32'(cfg_q.nz);
			default:             prdata = '0;
		endcase
	end

	esf_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.pix    (pix),
		.q_push (q_push),
		.q_data (q_din),
		.q_full (q_full)
	);

	esf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_dout),
		.empty  (q_empty)
	);

	esf_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (q_dout),
		.q_pop   (q_pop),
		.res     (res)
	);

endmodule
